// File: src/signed_network_rule_update_core_assert.svh
`ifndef SIGNED_NETWORK_RULE_UPDATE_CORE_ASSERT_SVH
`define SIGNED_NETWORK_RULE_UPDATE_CORE_ASSERT_SVH

// checked outside reset
`define SNRU_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define SNRU_CHK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/snru_pkg.sv
package snru_pkg;

  localparam int NODES   = 16;
  localparam int NODE_W  = $clog2(NODES);
  localparam int FIELD_W = 4;
  localparam int RULE_W  = 2;

  localparam logic [RULE_W-1:0] RULE_L4 = 2'd0;
  localparam logic [RULE_W-1:0] RULE_L6 = 2'd1;
  localparam logic [RULE_W-1:0] RULE_L7 = 2'd2;
  localparam logic [RULE_W-1:0] RULE_L8 = 2'd3;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef logic [FIELD_W-1:0] node_field_t;
  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [NODES-1:0]   row_t;
  typedef logic [RULE_W-1:0]  rule_t;

  typedef struct packed {
    logic        cmd;
    node_field_t origin_node;
    node_field_t dest_node;
    node_field_t third_node;
    logic        link_sign;
  } item_t;

  typedef struct packed {
    logic new_sign;
    logic absorbing;
  } result_t;

  function automatic node_t node_index(input node_field_t v);
    return node_t'(v % NODES);
  endfunction

endpackage

// File: src/snru_ram.sv
module snru_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: src/snru_rule_unit.sv
module snru_rule_unit (
  input  snru_pkg::rule_t rule_select,
  input  logic            od,
  input  logic            dr,
  input  logic            orr,
  output logic            next_bit
);

  logic prod;

  always_comb begin
    prod = ~(orr ^ dr);
    unique case (rule_select)
      snru_pkg::RULE_L4: next_bit = (od && dr && !orr) ? 1'b1 : prod;
      snru_pkg::RULE_L6: next_bit = prod;
      snru_pkg::RULE_L7: next_bit = dr ? (od ? 1'b1 : orr) : (od ? ~orr : 1'b0);
      snru_pkg::RULE_L8: next_bit = dr ? orr : (od ? ~orr : 1'b0);
      default:           next_bit = prod;
    endcase
  end

endmodule

// File: src/signed_network_rule_update_core.sv
// Signed link matrix of NODES x NODES one-bit links (1 is +1, 0 is -1), held as one row per
// node in a two-read-port RAM. A write beat stores one link and returns it with absorbing 0
// after the LOAD and APPLY states. A step beat rewrites link o-d by the rule chosen in
// cfg_data (0 L4, 1 L6, 2 L7, 3 L8), then checks every (o, d, r) triple with a single rule
// evaluator, one triple per cycle in SCAN with a row fetch in CWAIT before each (o, d) pair,
// ending early at the first triple whose rule would change its link. Every link must be
// written before the first step beat. The input stalls until the item is done; a finished
// result sits in the output register until taken.
`include "signed_network_rule_update_core_assert.svh"

module signed_network_rule_update_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_stall,
  input  snru_pkg::item_t         item,
  output logic                    result_valid,
  input  logic                    result_stall,
  output snru_pkg::result_t       result,
  input  logic                    cfg_we,
  input  snru_pkg::rule_t         cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_APPLY = 3'd2;
  localparam logic [2:0] ST_CWAIT = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_HOLD  = 3'd5;

  localparam snru_pkg::node_t LAST = snru_pkg::node_t'(snru_pkg::NODES - 1);

  logic [2:0]      state;
  snru_pkg::item_t item_r;
  snru_pkg::rule_t rule_select;
  snru_pkg::node_t o_cnt;
  snru_pkg::node_t d_cnt;
  snru_pkg::node_t r_cnt;
  logic            new_sign_r;
  logic            abs_flag;

  logic            scanning;
  snru_pkg::node_t addr_a;
  snru_pkg::node_t addr_b;
  snru_pkg::node_t rule_d;
  snru_pkg::node_t rule_r;
  snru_pkg::row_t  row_a;
  snru_pkg::row_t  row_b;
  snru_pkg::row_t  row_wdata;
  logic            ram_we;
  logic            od_bit;
  logic            rule_bit;
  logic            apply_bit;
  logic            mismatch;
  logic            last_triple;
  logic            finish;
  logic            finish_abs;
  logic            finish_sign;
  logic            out_free;
  logic            apply_step;
  logic            write_out;
  logic            scan_start;
  logic            result_src;
  logic            idle_clear;

  always_comb begin
    scanning  = (state == ST_CWAIT) || (state == ST_SCAN);
    addr_a    = scanning ? o_cnt : snru_pkg::node_index(item_r.origin_node);
    addr_b    = scanning ? d_cnt : snru_pkg::node_index(item_r.dest_node);
    rule_d    = scanning ? d_cnt : snru_pkg::node_index(item_r.dest_node);
    rule_r    = scanning ? r_cnt : snru_pkg::node_index(item_r.third_node);
    od_bit    = row_a[rule_d];
    apply_bit = (item_r.cmd == snru_pkg::CMD_STEP) ? rule_bit : item_r.link_sign;
    row_wdata = row_a;
    row_wdata[rule_d] = apply_bit;
    ram_we    = (state == ST_APPLY);
    mismatch  = (state == ST_SCAN) && (rule_bit != od_bit);
    last_triple = (o_cnt == LAST) && (d_cnt == LAST) && (r_cnt == LAST);
    out_free  = !result_valid || !result_stall;

    apply_step = (state == ST_APPLY) && (item_r.cmd == snru_pkg::CMD_STEP);
    write_out  = (state == ST_APPLY) && (item_r.cmd == snru_pkg::CMD_WRITE) && out_free;
    scan_start = (state == ST_CWAIT) && (o_cnt == '0) && (d_cnt == '0);
    result_src = (state == ST_APPLY) || (state == ST_SCAN) || (state == ST_HOLD);
    idle_clear = (state == ST_IDLE) && !result_valid;

    finish      = 1'b0;
    finish_abs  = 1'b0;
    finish_sign = new_sign_r;
    unique case (state)
      ST_APPLY: begin
        finish      = (item_r.cmd == snru_pkg::CMD_WRITE);
        finish_sign = apply_bit;
      end
      ST_SCAN: begin
        finish     = mismatch || last_triple;
        finish_abs = !mismatch;
      end
      ST_HOLD: begin
        finish     = 1'b1;
        finish_abs = abs_flag;
      end
      default: begin
        finish = 1'b0;
      end
    endcase
  end

  assign item_stall = (state != ST_IDLE);

  snru_ram #(
    .WIDTH (snru_pkg::NODES),
    .DEPTH (snru_pkg::NODES)
  ) u_rows (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (snru_pkg::node_index(item_r.origin_node)),
    .wdata   (row_wdata),
    .raddr_a (addr_a),
    .raddr_b (addr_b),
    .rdata_a (row_a),
    .rdata_b (row_b)
  );

  snru_rule_unit u_rule (
    .rule_select (rule_select),
    .od          (od_bit),
    .dr          (row_b[rule_r]),
    .orr         (row_a[rule_r]),
    .next_bit    (rule_bit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      rule_select  <= snru_pkg::RULE_L4;
    end else begin
      if (cfg_we) begin
        rule_select <= cfg_data;
      end
      if (finish && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            item_r <= item;
            state  <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state <= ST_APPLY;
        end
        ST_APPLY: begin
          new_sign_r <= apply_bit;
          o_cnt      <= '0;
          d_cnt      <= '0;
          if (!finish) begin
            state <= ST_CWAIT;
          end
        end
        ST_CWAIT: begin
          r_cnt <= '0;
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          r_cnt <= r_cnt + 1'b1;
          if (r_cnt == LAST) begin
            if (d_cnt == LAST) begin
              d_cnt <= '0;
              o_cnt <= o_cnt + 1'b1;
            end else begin
              d_cnt <= d_cnt + 1'b1;
            end
            if (!finish) begin
              state <= ST_CWAIT;
            end
          end
        end
        ST_HOLD: begin
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (finish) begin
        if (out_free) begin
          result.new_sign  <= finish_sign;
          result.absorbing <= finish_abs;
          state            <= ST_IDLE;
        end else begin
          abs_flag <= finish_abs;
          state    <= ST_HOLD;
        end
      end
    end
  end

  `SNRU_CHK(a_step_starts_scan, apply_step |=> scan_start, "check did not start")
  `SNRU_CHK(a_write_not_absorbing, write_out |=> (result_valid && !result.absorbing), "write")
  `SNRU_CHK(a_result_source, $rose(result_valid) |-> $past(result_src), "result from wrong state")
  `SNRU_CHK_ALWAYS(a_reset_idle, $past(rst) |-> idle_clear, "reset left the block busy")

endmodule

// File: tb/sv/snru_link_monitor.sv
module snru_link_monitor (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  snru_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_stall,
  input  snru_pkg::result_t result,
  input  logic              cfg_we,
  input  snru_pkg::rule_t   cfg_data,
  output int                mismatch_count,
  output int                outcomes_due
);
  timeunit 1ns;
  timeprecision 1ps;

  snru_pkg::row_t    links [snru_pkg::NODES];
  snru_pkg::rule_t   active_rule;
  snru_pkg::result_t pending_outcomes [$];

  function automatic logic rule_outcome(snru_pkg::rule_t sel, logic od, logic dr, logic orl);
    logic prod;
    prod = ~(orl ^ dr);
    case (sel)
      snru_pkg::RULE_L4: return (od && dr && !orl) ? 1'b1 : prod;
      snru_pkg::RULE_L6: return prod;
      snru_pkg::RULE_L7: return dr ? (od ? 1'b1 : orl) : (od ? ~orl : 1'b0);
      default:           return dr ? orl : (od ? ~orl : 1'b0);
    endcase
  endfunction

  function automatic logic network_settled();
    for (int o = 0; o < snru_pkg::NODES; o++)
      for (int d = 0; d < snru_pkg::NODES; d++)
        for (int r = 0; r < snru_pkg::NODES; r++)
          if (rule_outcome(active_rule, links[o][d], links[d][r], links[o][r]) != links[o][d])
            return 1'b0;
    return 1'b1;
  endfunction

  function automatic snru_pkg::result_t predict_outcome(snru_pkg::item_t beat);
    snru_pkg::node_t   o;
    snru_pkg::node_t   d;
    snru_pkg::node_t   r;
    snru_pkg::result_t outcome;
    o = snru_pkg::node_t'(beat.origin_node % snru_pkg::NODES);
    d = snru_pkg::node_t'(beat.dest_node % snru_pkg::NODES);
    r = snru_pkg::node_t'(beat.third_node % snru_pkg::NODES);
    if (beat.cmd == snru_pkg::CMD_WRITE) begin
      links[o][d] = beat.link_sign;
      outcome.new_sign = beat.link_sign;
      outcome.absorbing = 1'b0;
    end else begin
      links[o][d] = rule_outcome(active_rule, links[o][d], links[d][r], links[o][r]);
      outcome.new_sign = links[o][d];
      outcome.absorbing = network_settled();
    end
    return outcome;
  endfunction

  always @(posedge clk) begin
    snru_pkg::result_t want;
    snru_pkg::result_t fresh;
    if (rst) begin
      active_rule = snru_pkg::RULE_L4;
      pending_outcomes.delete();
      mismatch_count = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (pending_outcomes.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got new_sign %0b absorbing %0b",
                   $time, result.new_sign, result.absorbing);
          mismatch_count++;
        end else begin
          want = pending_outcomes.pop_front();
          if (result.new_sign !== want.new_sign) begin
            $display("%0t: new_sign mismatch, expected %0b, got %0b",
                     $time, want.new_sign, result.new_sign);
            mismatch_count++;
          end
          if (result.absorbing !== want.absorbing) begin
            $display("%0t: absorbing mismatch, expected %0b, got %0b",
                     $time, want.absorbing, result.absorbing);
            mismatch_count++;
          end
        end
      end
      if (item_valid && !item_stall) begin
        fresh = predict_outcome(item);
        pending_outcomes = {pending_outcomes, fresh};
      end
      if (cfg_we) begin
        active_rule = cfg_data;
      end
    end
    outcomes_due = pending_outcomes.size();
  end

endmodule

// File: tb/sv/tb_signed_network_rule_update_core.sv
module tb_signed_network_rule_update_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT     = 20000;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 6;

  typedef enum {FILL_ALL_POS, FILL_ALL_NEG, FILL_BALANCED, FILL_SCRAMBLED} fill_kind_t;

  logic              clk;
  logic              rst;
  logic              item_valid;
  logic              item_stall;
  snru_pkg::item_t   item;
  logic              result_valid;
  logic              result_stall;
  snru_pkg::result_t result;
  logic              cfg_we;
  snru_pkg::rule_t   cfg_data;
  int                mismatch_count;
  int                outcomes_due;
  int                quiet_cycles;
  bit                calm;

  fill_kind_t     fill_kind;
  snru_pkg::row_t group_mask;
  snru_pkg::row_t scrambled_rows [snru_pkg::NODES];

  snru_pkg::rule_t phase_rule [PHASES] = '{snru_pkg::RULE_L4, snru_pkg::RULE_L6,
                                           snru_pkg::RULE_L7, snru_pkg::RULE_L8,
                                           snru_pkg::RULE_L8, snru_pkg::RULE_L4};

  signed_network_rule_update_core uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  snru_link_monitor monitor (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .item           (item),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result         (result),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .outcomes_due   (outcomes_due)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int idle_gap();
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic logic fill_link(int a, int b);
    case (fill_kind)
      FILL_ALL_POS:  return 1'b1;
      FILL_ALL_NEG:  return 1'b0;
      FILL_BALANCED: return group_mask[a] ~^ group_mask[b];
      default:       return scrambled_rows[a][b];
    endcase
  endfunction

  task automatic send_beat(snru_pkg::item_t beat);
    int gap;
    gap = idle_gap();
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item <= beat;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic send_link(int o, int d, logic sign);
    snru_pkg::item_t beat;
    beat.cmd = snru_pkg::CMD_WRITE;
    beat.origin_node = snru_pkg::node_field_t'(o);
    beat.dest_node = snru_pkg::node_field_t'(d);
    beat.third_node = snru_pkg::node_field_t'($urandom_range(0, 15));
    beat.link_sign = sign;
    send_beat(beat);
  endtask

  task automatic send_step(int o, int d, int r);
    snru_pkg::item_t beat;
    beat.cmd = snru_pkg::CMD_STEP;
    beat.origin_node = snru_pkg::node_field_t'(o);
    beat.dest_node = snru_pkg::node_field_t'(d);
    beat.third_node = snru_pkg::node_field_t'(r);
    beat.link_sign = 1'($urandom);
    send_beat(beat);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    item_valid <= 1'b0;
    while (outcomes_due != 0) @(negedge clk);
  endtask

  // result side backpressure
  initial begin
    int gap;
    result_stall = 1'b1;
    forever begin
      gap = idle_gap();
      if (gap > 0) begin
        result_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int o;
    int d;
    int r;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_data = snru_pkg::RULE_L4;
    calm = 1'b0;
    fill_kind = FILL_ALL_POS;
    group_mask = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // every link is loaded before any step beat
    fill_kind = FILL_BALANCED;
    group_mask = snru_pkg::row_t'($urandom);
    for (int a = 0; a < snru_pkg::NODES; a++) scrambled_rows[a] = snru_pkg::row_t'($urandom);
    for (int a = 0; a < snru_pkg::NODES; a++) begin
      if (a % 4 == 0) calm = ($urandom_range(0, 2) == 0);
      for (int b = 0; b < snru_pkg::NODES; b++) send_link(a, b, fill_link(a, b));
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      cfg_we <= 1'b1;
      cfg_data <= phase_rule[p];
      @(negedge clk);
      cfg_we <= 1'b0;

      if (p == 0) begin
        send_step(0, 0, 0);
        send_step(15, 15, 15);
        send_step(0, 15, 0);
        send_step(15, 0, 15);
        send_link(0, 15, 1'b0);
        send_step(0, 3, 15);
        send_step(0, 15, 15);
        send_link(15, 0, 1'b0);
        send_step(15, 0, 0);
        send_link(0, 15, 1'b1);
        send_link(15, 0, 1'b1);
        send_step(7, 8, 9);
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 8 == 0) calm = ($urandom_range(0, 3) == 0);
        o = $urandom_range(0, snru_pkg::NODES - 1);
        d = $urandom_range(0, snru_pkg::NODES - 1);
        r = $urandom_range(0, snru_pkg::NODES - 1);
        if ($urandom_range(0, 9) == 0) d = o;
        if ($urandom_range(0, 9) == 0) r = d;
        if ($urandom_range(0, 99) < 55)
          send_step(o, d, r);
        else if ($urandom_range(0, 3) != 0)
          send_link(o, d, fill_link(o, d));
        else
          send_link(o, d, 1'($urandom));
      end
    end

    wait_drained();
    repeat (16) @(negedge clk);
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
